>>> src/multichannel_histogram_peak_unit_defines.svh
// ----------------------------------------------------------------------------
// Histogram peak unit assertion macros
// Shared concurrent assertion helpers, clocked on clock, idle in reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_HISTOGRAM_PEAK_UNIT_DEFINES_SVH
`define MULTICHANNEL_HISTOGRAM_PEAK_UNIT_DEFINES_SVH

// same-cycle implication
`define MHP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mhp_pkg.sv
// ----------------------------------------------------------------------------
// Histogram peak unit package
// Sizes, operation codes, controller/datapath structs and counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mhp_pkg;

   // spectrum geometry
   localparam int CHANNELS    = 8;
   localparam int BINS        = 1024;
   localparam int COUNT_WIDTH = 32;

   // fixed beat field widths
   localparam int OP_FIELD_W   = 2;
   localparam int CHAN_FIELD_W = 4;
   localparam int BIN_FIELD_W  = 10;
   localparam int POS_FIELD_W  = 10;
   localparam int OUT_W        = 32;

   // derived sizes
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BIN_W      = $clog2(BINS);
   localparam int CMEM_DEPTH = CHANNELS * BINS;
   localparam int CADDR_W    = $clog2(CMEM_DEPTH);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [OP_FIELD_W-1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // latch beat, issue memory reads
      logic commit;    // write back, update peaks, load result
      logic clr_init;  // zero peaks and total, restart sweep
      logic clr_step;  // zero one channel entry, and the sum entry while in range
      logic zero_out;  // load an all-zero result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic slot_free; // result register can take a new beat
      logic clr_last;  // sweep is at its final entry
   } sts_type;

   // saturating increment of a bin counter
   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

   // report a counter on a 32-bit field, saturating wider counts
   function automatic logic [OUT_W-1:0] clamp_out(input count_type v);
      logic [OUT_W-1:0] r;
      if ((COUNT_WIDTH > OUT_W) && (v > count_type'({OUT_W{1'b1}}))) begin
         r = '1;
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/mhp_if.sv
// ----------------------------------------------------------------------------
// Histogram peak unit channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhp_req_if;
   import mhp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_FIELD_W-1:0]   operation;
   logic [CHAN_FIELD_W-1:0] channel;
   logic [BIN_FIELD_W-1:0]  bin;
   logic                    use_sum;

   modport source (output valid, output operation, output channel, output bin,
                   output use_sum, input ready);
   modport sink   (input valid, input operation, input channel, input bin,
                   input use_sum, output ready);
endinterface

interface mhp_rsp_if;
   import mhp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OUT_W-1:0]       bin_count;
   logic [POS_FIELD_W-1:0] peak_position;
   logic [OUT_W-1:0]       peak_count;
   logic [OUT_W-1:0]       total_events;
   logic                   range_error;

   modport source (output valid, output bin_count, output peak_position,
                   output peak_count, output total_events, output range_error,
                   input ready);
   modport sink   (input valid, input bin_count, input peak_position,
                   input peak_count, input total_events, input range_error,
                   output ready);
endinterface

`default_nettype wire

>>> src/multichannel_histogram_peak_unit.sv
// ----------------------------------------------------------------------------
// Multichannel histogram peak unit
// Per-channel and sum spectra with peak tracking, behind valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
// - req_if carries one command per beat: count event, read bin and peak,
//   or clear all. rsp_if returns exactly one result beat per command.
// - count and read: the accept cycle issues the bin memory reads; the execute
//   state then increments, writes back, updates the peak and loads the result
//   register once it is free. A new command is accepted only after the commit,
//   set by the registered read of the single-port bin memories.
// - clear all sweeps the 8192 channel memory entries one entry a cycle, zeroing
//   the sum memory alongside, then loads an all-zero reply once the slot is free.
// - after reset the same sweep runs with req_if.ready low;
//   no result is produced for it.
// - results wait in an output register; the next command is still accepted
//   while one waits, but its commit holds until rsp_if takes the waiting beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_histogram_peak_unit_defines.svh"

module multichannel_histogram_peak_unit (
   input wire logic  clock,
   input wire logic  reset,
   mhp_req_if.sink   req_if,
   mhp_rsp_if.source rsp_if
);
   import mhp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    ready;

   // sequencer
   mhp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // memories and arithmetic
   mhp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_if.operation),
      .req_channel   (req_if.channel),
      .req_bin       (req_if.bin),
      .req_use_sum   (req_if.use_sum),
      .rsp_if        (rsp_if)
   );

   assign req_if.ready = ready;

   // checks on controller and datapath cooperation
   `MHP_ASSERT_NOW(a_no_accept_on_commit, req_if.valid && ready, !cmd.commit, "accept during commit")
   `MHP_ASSERT_NOW(a_commit_slot_free, cmd.commit || cmd.zero_out, sts.slot_free, "result overwritten")
   `MHP_ASSERT_NEXT(a_commit_shows, cmd.commit || cmd.zero_out, rsp_if.valid, "result beat missing")
   `MHP_ASSERT_NOW(a_sweep_blocks, cmd.clr_step, !ready && !cmd.load, "accept during clear sweep")

endmodule

`default_nettype wire

>>> src/mhp_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram peak unit controller
// Sequences accept, execute, memory clear sweep and clear reply.
// ----------------------------------------------------------------------------
`default_nettype none

module mhp_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [mhp_pkg::OP_FIELD_W-1:0] req_operation,
   output logic                                req_ready,
   input  wire mhp_pkg::sts_type               sts,
   output mhp_pkg::cmd_type                    cmd
);
   import mhp_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;

   // state and pending clear reply
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      reply_in  = reply_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (op_type'(req_operation) == OP_CLEAR) begin
                  cmd.clr_init = 1'b1;
                  reply_in     = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (sts.slot_free) begin
               cmd.zero_out = 1'b1;
               reply_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/mhp_dp.sv
// ----------------------------------------------------------------------------
// Histogram peak unit datapath
// Bin memories, peak and total registers, increment logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhp_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mhp_pkg::cmd_type                 cmd,
   output mhp_pkg::sts_type                      sts,
   input  wire logic [mhp_pkg::OP_FIELD_W-1:0]   req_operation,
   input  wire logic [mhp_pkg::CHAN_FIELD_W-1:0] req_channel,
   input  wire logic [mhp_pkg::BIN_FIELD_W-1:0]  req_bin,
   input  wire logic                             req_use_sum,
   mhp_rsp_if.source                             rsp_if
);
   import mhp_pkg::*;

   localparam logic [CADDR_W-1:0] CLR_LAST = CADDR_W'(CMEM_DEPTH - 1);

   // bin memories
   count_type chan_mem [CMEM_DEPTH];
   count_type sum_mem  [BINS];
   count_type ch_rd_ff, sum_rd_ff;

   // latched beat
   op_type             op_ff;
   logic               ch_ok_ff, bn_ok_ff, use_sum_ff;
   logic [CH_W-1:0]    ch_idx_ff;
   logic [BIN_W-1:0]   bin_ff;
   logic [CADDR_W-1:0] caddr_ff;

   // spectrum state
   logic [BIN_W-1:0]   ch_pk_pos_ff [CHANNELS];
   count_type          ch_pk_cnt_ff [CHANNELS];
   logic [BIN_W-1:0]   sum_pk_pos_ff;
   count_type          sum_pk_cnt_ff;
   logic [OUT_W-1:0]   total_ff, total_in;
   logic [CADDR_W-1:0] clr_cnt_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [OUT_W-1:0]       bin_count_ff, bin_count_in;
   logic [POS_FIELD_W-1:0] peak_pos_ff, peak_pos_in;
   logic [OUT_W-1:0]       peak_cnt_ff, peak_cnt_in;
   logic [OUT_W-1:0]       total_out_ff, total_out_in;
   logic                   range_err_ff, range_err_in;

   // request decode
   logic               ch_ok_req, bn_ok_req;
   logic [CH_W-1:0]    ch_idx_req;
   logic [BIN_W-1:0]   bin_req;
   logic [CADDR_W-1:0] caddr_req;

   // execute logic
   count_type        sum_new, ch_new, ch_cur_cnt;
   logic [BIN_W-1:0] ch_cur_pos;
   logic             sum_move, ch_move, do_count, clr_sum_en;

   assign ch_ok_req  = 32'(req_channel) < 32'(CHANNELS);
   assign bn_ok_req  = 32'(req_bin) < 32'(BINS);
   assign ch_idx_req = CH_W'(req_channel);
   assign bin_req    = BIN_W'(req_bin);
   assign caddr_req  = CADDR_W'(CADDR_W'(ch_idx_req) * CADDR_W'(BINS)) + CADDR_W'(bin_req);
   assign clr_sum_en = 32'(clr_cnt_ff) < 32'(BINS);

   // increment, peak tracking and result selection
   always_comb begin
      sum_new    = sat_inc(sum_rd_ff);
      ch_new     = sat_inc(ch_rd_ff);
      ch_cur_pos = ch_pk_pos_ff[ch_idx_ff];
      ch_cur_cnt = ch_pk_cnt_ff[ch_idx_ff];
      sum_move   = (sum_new > sum_pk_cnt_ff) || (bin_ff == sum_pk_pos_ff);
      ch_move    = (ch_new > ch_cur_cnt) || (bin_ff == ch_cur_pos);
      do_count   = (op_ff == OP_COUNT) && bn_ok_ff;
      total_in   = (total_ff == '1) ? total_ff : total_ff + OUT_W'(1);

      bin_count_in = '0;
      peak_pos_in  = '0;
      peak_cnt_in  = '0;
      total_out_in = total_ff;
      range_err_in = 1'b0;
      unique case (op_ff)
         OP_COUNT: begin
            if (!bn_ok_ff) begin
               range_err_in = 1'b1;
            end else begin
               total_out_in = total_in;
               if (ch_ok_ff) begin
                  bin_count_in = clamp_out(ch_new);
                  peak_pos_in  = POS_FIELD_W'(ch_move ? bin_ff : ch_cur_pos);
                  peak_cnt_in  = clamp_out(ch_move ? ch_new : ch_cur_cnt);
               end else begin
                  // unknown channel reports the sum spectrum
                  range_err_in = 1'b1;
                  bin_count_in = clamp_out(sum_new);
                  peak_pos_in  = POS_FIELD_W'(sum_move ? bin_ff : sum_pk_pos_ff);
                  peak_cnt_in  = clamp_out(sum_move ? sum_new : sum_pk_cnt_ff);
               end
            end
         end
         OP_READ: begin
            if (use_sum_ff) begin
               bin_count_in = bn_ok_ff ? clamp_out(sum_rd_ff) : '0;
               peak_pos_in  = POS_FIELD_W'(sum_pk_pos_ff);
               peak_cnt_in  = clamp_out(sum_pk_cnt_ff);
            end else if (ch_ok_ff) begin
               bin_count_in = bn_ok_ff ? clamp_out(ch_rd_ff) : '0;
               peak_pos_in  = POS_FIELD_W'(ch_cur_pos);
               peak_cnt_in  = clamp_out(ch_cur_cnt);
            end else begin
               range_err_in = 1'b1;
            end
            if (!bn_ok_ff) begin
               range_err_in = 1'b1;
            end
         end
         OP_CLEAR, OP_RSVD: begin
            // reserved code reports only the total
            total_out_in = total_ff;
         end
         default: begin
            total_out_in = total_ff;
         end
      endcase
   end

   // channel bin memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         chan_mem[clr_cnt_ff] <= '0;
      end else if (cmd.commit && do_count && ch_ok_ff) begin
         chan_mem[caddr_ff] <= ch_new;
      end
      if (cmd.load) begin
         ch_rd_ff <= chan_mem[caddr_req];
      end
   end

   // sum bin memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         if (clr_sum_en) begin
            sum_mem[BIN_W'(clr_cnt_ff)] <= '0;
         end
      end else if (cmd.commit && do_count) begin
         sum_mem[bin_ff] <= sum_new;
      end
      if (cmd.load) begin
         sum_rd_ff <= sum_mem[bin_req];
      end
   end

   // beat latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_operation);
         ch_ok_ff   <= ch_ok_req;
         bn_ok_ff   <= bn_ok_req;
         use_sum_ff <= req_use_sum;
         ch_idx_ff  <= ch_idx_req;
         bin_ff     <= bin_req;
         caddr_ff   <= caddr_req;
      end
   end

   // peaks, total and sweep counter
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) begin
         for (int i = 0; i < CHANNELS; i++) begin
            ch_pk_pos_ff[i] <= '0;
            ch_pk_cnt_ff[i] <= '0;
         end
         sum_pk_pos_ff <= '0;
         sum_pk_cnt_ff <= '0;
         total_ff      <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + CADDR_W'(1);
         end
         if (cmd.commit && do_count) begin
            total_ff <= total_in;
            if (sum_move) begin
               sum_pk_pos_ff <= bin_ff;
               sum_pk_cnt_ff <= sum_new;
            end
            if (ch_ok_ff && ch_move) begin
               ch_pk_pos_ff[ch_idx_ff] <= bin_ff;
               ch_pk_cnt_ff[ch_idx_ff] <= ch_new;
            end
         end
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit || cmd.zero_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         bin_count_ff <= bin_count_in;
         peak_pos_ff  <= peak_pos_in;
         peak_cnt_ff  <= peak_cnt_in;
         total_out_ff <= total_out_in;
         range_err_ff <= range_err_in;
      end else if (cmd.zero_out) begin
         bin_count_ff <= '0;
         peak_pos_ff  <= '0;
         peak_cnt_ff  <= '0;
         total_out_ff <= '0;
         range_err_ff <= 1'b0;
      end
   end

   assign sts.slot_free = !rsp_valid_ff || rsp_if.ready;
   assign sts.clr_last  = (clr_cnt_ff == CLR_LAST);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.bin_count     = bin_count_ff;
   assign rsp_if.peak_position = peak_pos_ff;
   assign rsp_if.peak_count    = peak_cnt_ff;
   assign rsp_if.total_events  = total_out_ff;
   assign rsp_if.range_error   = range_err_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb_multichannel_histogram_peak_unit.sv
// ----------------------------------------------------------------------------
// Histogram peak unit testbench
// Drives count, read, clear and reserved commands through the request channel
// with bursty timing, predicts every reply from a local model of the spectra,
// peaks and event total, and checks each response beat in order while the
// response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_multichannel_histogram_peak_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mhp_pkg::*;

   // one predicted or observed reply
   typedef struct packed {
      logic [OUT_W-1:0]       bin_count;
      logic [POS_FIELD_W-1:0] peak_position;
      logic [OUT_W-1:0]       peak_count;
      logic [OUT_W-1:0]       total_events;
      logic                   range_error;
   } hist_reply_type;

   logic clock = 1'b0;
   logic reset;

   mhp_req_if req_bus ();
   mhp_rsp_if rsp_bus ();

   multichannel_histogram_peak_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #1 clock = ~clock;

   // local copy of the histogram state
   count_type              chan_counts [CHANNELS][BINS];
   count_type              sum_counts [BINS];
   int unsigned            chan_peak [CHANNELS];
   int unsigned            sum_peak;
   logic [31:0]            events_seen;

   hist_reply_type         pending_replies[$];
   int unsigned            mismatch_count = 0;
   int unsigned            burst_left = 0;
   bit                     sender_gaps_on = 1'b1;
   logic [BIN_FIELD_W-1:0] hot_bins [4];

   // wipe every store
   function automatic void wipe_histograms();
      for (int c = 0; c < CHANNELS; c++) begin
         chan_peak[c] = 0;
         for (int b = 0; b < BINS; b++) chan_counts[c][b] = '0;
      end
      for (int b = 0; b < BINS; b++) sum_counts[b] = '0;
      sum_peak = 0;
      events_seen = '0;
   endfunction

   function automatic count_type spectrum_at(input bit from_sum, input int ch, input int b);
      return from_sum ? sum_counts[b] : chan_counts[ch][b];
   endfunction

   // counters wider than the reply field report as all ones
   function automatic logic [OUT_W-1:0] to_reply_field(input count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_W-1:0];
   endfunction

   // increment one bin, saturating, and move the peak on a strictly larger count
   function automatic void bump_bin(input bit to_sum, input int ch, input int b);
      count_type   v;
      int unsigned pk;
      v  = spectrum_at(to_sum, ch, b);
      pk = to_sum ? sum_peak : chan_peak[ch];
      if (v != '1) v = v + 1'b1;
      if (to_sum) sum_counts[b] = v;
      else chan_counts[ch][b] = v;
      if (v > spectrum_at(to_sum, ch, pk)) begin
         if (to_sum) sum_peak = b;
         else chan_peak[ch] = b;
      end
   endfunction

   // apply one accepted command to the local state and return its reply
   function automatic hist_reply_type apply_command(input op_type op, input logic [3:0] ch,
                                                    input logic [9:0] bn, input logic sum_sel);
      hist_reply_type r;
      bit             ch_ok;
      bit             bn_ok;
      bit             have_spec;
      bit             spec_is_sum;
      int unsigned    pk;
      count_type      bc;
      r           = '0;
      ch_ok       = int'(ch) < CHANNELS;
      bn_ok       = int'(bn) < BINS;
      have_spec   = 1'b0;
      spec_is_sum = 1'b0;
      pk          = 0;
      bc          = '0;
      case (op)
         OP_COUNT: begin
            if (!bn_ok) begin
               r.range_error = 1'b1;
            end else begin
               if (events_seen != '1) events_seen = events_seen + 1'b1;
               bump_bin(1'b1, 0, int'(bn));
               have_spec = 1'b1;
               if (ch_ok) begin
                  bump_bin(1'b0, int'(ch), int'(bn));
                  pk = chan_peak[ch];
               end else begin
                  r.range_error = 1'b1;
                  spec_is_sum   = 1'b1;
                  pk            = sum_peak;
               end
               bc = spectrum_at(spec_is_sum, ch_ok ? int'(ch) : 0, int'(bn));
            end
         end
         OP_READ: begin
            if (sum_sel) begin
               have_spec   = 1'b1;
               spec_is_sum = 1'b1;
               pk          = sum_peak;
            end else if (ch_ok) begin
               have_spec = 1'b1;
               pk        = chan_peak[ch];
            end else begin
               r.range_error = 1'b1;
            end
            if (!bn_ok) r.range_error = 1'b1;
            if (have_spec && bn_ok)
               bc = spectrum_at(spec_is_sum, ch_ok ? int'(ch) : 0, int'(bn));
         end
         OP_CLEAR: wipe_histograms();
         default: ;
      endcase
      if (have_spec && pk < BINS) begin
         r.peak_position = POS_FIELD_W'(pk);
         r.peak_count    = to_reply_field(spectrum_at(spec_is_sum, ch_ok ? int'(ch) : 0, pk));
      end
      r.bin_count    = to_reply_field(bc);
      r.total_events = events_seen;
      return r;
   endfunction

   // send one command beat, idling between bursts, and record its reply
   task automatic send_command(input op_type op, input logic [3:0] ch,
                               input logic [9:0] bn, input logic sum_sel);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (!sender_gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.channel   <= ch;
      req_bus.bin       <= bn;
      req_bus.use_sum   <= sum_sel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_replies.push_back(apply_command(op, ch, bn, sum_sel));
   endtask

   // hold the request side until every reply has come back
   task automatic wait_for_replies();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic pick_hot_bins();
      for (int i = 0; i < 4; i++) hot_bins[i] = BIN_FIELD_W'($urandom_range(0, BINS - 1));
   endtask

   // field extremes and out-of-range channels
   task automatic test_count_extremes();
      send_command(OP_COUNT, 4'd0, 10'd0, 1'b0);
      send_command(OP_COUNT, 4'd7, 10'd1023, 1'b1);
      send_command(OP_COUNT, 4'd8, 10'd5, 1'b0);
      send_command(OP_COUNT, 4'd15, 10'd1023, 1'b1);
      send_command(OP_READ, 4'd15, 10'd0, 1'b0);
      send_command(OP_READ, 4'd15, 10'd1023, 1'b1);
      send_command(OP_READ, 4'd7, 10'd1023, 1'b0);
   endtask

   // equal count leaves the peak, a larger one moves it
   task automatic test_peak_tracking();
      send_command(OP_COUNT, 4'd3, 10'd10, 1'b0);
      send_command(OP_COUNT, 4'd3, 10'd20, 1'b0);
      send_command(OP_READ, 4'd3, 10'd20, 1'b0);
      send_command(OP_COUNT, 4'd3, 10'd20, 1'b0);
      send_command(OP_READ, 4'd3, 10'd10, 1'b0);
      send_command(OP_READ, 4'd15, 10'd20, 1'b1);
   endtask

   // reserved operation, then clear all and counting afresh
   task automatic test_reserved_and_clear();
      send_command(OP_RSVD, 4'd15, 10'd1023, 1'b1);
      send_command(OP_CLEAR, 4'd0, 10'd0, 1'b0);
      send_command(OP_READ, 4'd7, 10'd1023, 1'b0);
      send_command(OP_READ, 4'd0, 10'd0, 1'b1);
      send_command(OP_COUNT, 4'd1, 10'd512, 1'b0);
      send_command(OP_RSVD, 4'd0, 10'd0, 1'b0);
   endtask

   // pause with replies outstanding until all have drained
   task automatic test_drain_pause();
      for (int i = 0; i < 8; i++)
         send_command(OP_COUNT, 4'($urandom_range(0, 7)), hot_bins[i % 4], 1'b0);
      wait_for_replies();
      send_command(OP_READ, 4'd0, hot_bins[0], 1'b1);
   endtask

   // mostly counts on a few hot bins so peaks keep moving, plus reads and noise
   task automatic test_random_traffic();
      int          clear_at_a;
      int          clear_at_b;
      int          pick;
      op_type      op;
      logic [3:0]  ch;
      logic [9:0]  bn;
      clear_at_a = $urandom_range(300, 700);
      clear_at_b = $urandom_range(900, 1400);
      for (int i = 0; i < 1600; i++) begin
         if (i % 200 == 0) begin
            sender_gaps_on = $urandom_range(0, 2) != 0;
            pick_hot_bins();
         end
         if (i == 800) wait_for_replies();
         if (i == clear_at_a || i == clear_at_b) begin
            send_command(OP_CLEAR, 4'($urandom), 10'($urandom), 1'($urandom));
            pick_hot_bins();
         end else begin
            pick = $urandom_range(0, 99);
            op   = (pick < 60) ? OP_COUNT : (pick < 95) ? OP_READ : OP_RSVD;
            ch   = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
            bn   = $urandom_range(0, 1) ? hot_bins[$urandom_range(0, 3)]
                                        : 10'($urandom_range(0, BINS - 1));
            send_command(op, ch, bn, 1'($urandom));
         end
      end
   endtask

   // response stall pattern: the mode switches at random among four ready modes
   int unsigned stall_cycle = 0;
   int unsigned stall_mode  = 0;
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(0, 9) < 7;
         2: rsp_bus.ready <= (stall_cycle % 4) == 0;
         default: rsp_bus.ready <= $urandom_range(0, 9) < 3;
      endcase
   end

   // compare each response beat with the oldest pending reply
   always @(posedge clock) begin : check_replies
      hist_reply_type want;
      hist_reply_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.bin_count, rsp_bus.peak_position, rsp_bus.peak_count,
                 rsp_bus.total_events, rsp_bus.range_error};
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: reply beat with none pending: %s %0d pos %0d peak %0d %s %0d err %0b",
                        $realtime, "count", got.bin_count, got.peak_position, got.peak_count,
                        "total", got.total_events, got.range_error);
         end else begin
            want = pending_replies.pop_front();
            if (got.bin_count !== want.bin_count || got.peak_position !== want.peak_position ||
                got.peak_count !== want.peak_count || got.total_events !== want.total_events ||
                got.range_error !== want.range_error) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: reply mismatch", $realtime);
                  $display("   expected count %0d pos %0d peak %0d total %0d err %0b",
                           want.bin_count, want.peak_position, want.peak_count,
                           want.total_events, want.range_error);
                  $display("   actual   count %0d pos %0d peak %0d total %0d err %0b",
                           got.bin_count, got.peak_position, got.peak_count,
                           got.total_events, got.range_error);
               end
            end
         end
      end
   end

   // run sequence
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_COUNT;
      req_bus.channel   = '0;
      req_bus.bin       = '0;
      req_bus.use_sum   = 1'b0;
      rsp_bus.ready     = 1'b0;
      wipe_histograms();
      pick_hot_bins();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_count_extremes();
      test_peak_tracking();
      test_reserved_and_clear();
      test_drain_pause();
      test_random_traffic();

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
